// ===== src/pal_pkg.sv =====
`default_nettype none
package pal_pkg;

	localparam int CAPACITY = 16;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = 5;
	localparam int DW = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ERROR   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	localparam logic [CW-1:0] NO_INDEX = 5'b11111;

	typedef struct packed {
		logic [DW-1:0] largest;
		logic [DW-1:0] smallest;
		logic [AW-1:0] first;
		logic          present;
		logic [CW-1:0] count;
	} scan_res_t;

endpackage
`default_nettype wire

// ===== src/pal_mem.sv =====
`default_nettype none
module pal_mem (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [pal_pkg::AW-1:0] waddr,
	input  wire logic [pal_pkg::DW-1:0] wdata,
	input  wire logic [pal_pkg::AW-1:0] raddr,
	output logic      [pal_pkg::DW-1:0] rdata
);

	logic [pal_pkg::DW-1:0] mem [pal_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/pal_scan.sv =====
`default_nettype none
module pal_scan (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   clear,
	input  wire logic                   vld,
	input  wire logic [pal_pkg::DW-1:0] data,
	input  wire logic [pal_pkg::AW-1:0] index,
	input  wire logic [pal_pkg::DW-1:0] target,
	output pal_pkg::scan_res_t          res
);

	logic                   seen_q;
	logic                   present_q;
	logic [pal_pkg::CW-1:0] count_q;
	logic [pal_pkg::AW-1:0] first_q;
	logic [pal_pkg::DW-1:0] max_q;
	logic [pal_pkg::DW-1:0] min_q;
	logic                   eq;
	logic                   gt;
	logic                   lt;

	// one equality and two signed compares, reused for every entry
	assign eq = (data == target);
	assign gt = $signed(data) > $signed(max_q);
	assign lt = $signed(data) < $signed(min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			present_q <= 1'b0;
			count_q   <= '0;
		end else if (clear) begin
			seen_q    <= 1'b0;
			present_q <= 1'b0;
			count_q   <= '0;
		end else if (vld) begin
			seen_q <= 1'b1;
			if (eq) begin
				present_q <= 1'b1;
				count_q   <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld) begin
			if (!seen_q || gt) begin
				max_q <= data;
			end
			if (!seen_q || lt) begin
				min_q <= data;
			end
			if (eq && !present_q) begin
				first_q <= index;
			end
		end
	end

	always_comb begin
		res.largest  = seen_q ? max_q : '0;
		res.smallest = seen_q ? min_q : '0;
		res.first    = first_q;
		res.present  = present_q;
		res.count    = count_q;
	end

endmodule
`default_nettype wire

// ===== src/positional_array_list_top.sv =====
// channel   | handshake           | fields
// request   | start in, busy out  | action, position, value
// result    | done out (1 cycle)  | status, fill, first_index, present, match_count,
//           |                     | largest, smallest, empty_res
// A request is taken when start is high and busy is low; busy stays high until done.
// An accepted insert or delete first shifts the entries that move, an insert then writes
// the new word, and every request ends with a scan of the filled entries; the single
// memory read port paces both the shift and the scan.
// Reset clears the fill count and the sequencer; list contents need no clearing.
// done lasts one cycle and cannot be held off by the receiver.
`default_nettype none
module positional_array_list_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    action,
	input  wire logic [4:0]                    position,
	input  wire logic signed [31:0]            value,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [4:0]                         fill,
	output logic signed [4:0]                  first_index,
	output logic                               present,
	output logic [4:0]                         match_count,
	output logic signed [31:0]                 largest,
	output logic signed [31:0]                 smallest,
	output logic                               empty_res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOVE = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam int AW = pal_pkg::AW;
	localparam int CW = pal_pkg::CW;
	localparam int DW = pal_pkg::DW;
	localparam logic [CW-1:0] CAP = CW'(pal_pkg::CAPACITY);
	localparam logic [AW-1:0] CAP_M2 = AW'(pal_pkg::CAPACITY - 2);

	logic [2:0]    state_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] cnt_q;
	logic          mv_s1;
	logic [CW-1:0] scan_idx_q;
	logic          scan_vld_s1;

	logic [1:0]    act_q;
	logic [CW-1:0] pos_q;
	logic [DW-1:0] val_q;
	logic [1:0]    status_q;
	logic [AW-1:0] mv_rd_q;
	logic          up_q;
	logic [AW-1:0] mv_wa_s1;
	logic [AW-1:0] scan_ix_s1;

	logic          accept;
	logic          ins_ok;
	logic          full;
	logic [2:0]    plan_state;
	logic [1:0]    plan_status;
	logic [CW-1:0] plan_cnt;
	logic [AW-1:0] plan_rd;
	logic          plan_up;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;
	pal_pkg::scan_res_t scan_res;
	logic          is_query;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (used_q == CAP);
	assign ins_ok = (position <= used_q) && (position < CAP);

	always_comb begin
		plan_state  = S_SCAN;
		plan_status = pal_pkg::ST_ERROR;
		plan_cnt    = '0;
		plan_rd     = '0;
		plan_up     = 1'b0;
		unique case (action)
			pal_pkg::ACT_INSERT: begin
				if (ins_ok) begin
					plan_state = S_MOVE;
					if (full) begin
						plan_status = pal_pkg::ST_DROPPED;
						plan_cnt    = CAP - 1'b1 - position;
						plan_rd     = CAP_M2;
					end else begin
						plan_status = pal_pkg::ST_OK;
						plan_cnt    = used_q - position;
						plan_rd     = AW'(used_q - 1'b1);
					end
				end
			end
			pal_pkg::ACT_DELETE: begin
				if (position < used_q) begin
					plan_state  = S_MOVE;
					plan_status = pal_pkg::ST_OK;
					plan_cnt    = used_q - 1'b1 - position;
					plan_rd     = AW'(position + 1'b1);
					plan_up     = 1'b1;
				end
			end
			pal_pkg::ACT_QUERY: begin
				plan_status = pal_pkg::ST_OK;
			end
			default: begin
				plan_status = pal_pkg::ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			cnt_q       <= '0;
			mv_s1       <= 1'b0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q    <= plan_state;
						cnt_q      <= plan_cnt;
						scan_idx_q <= '0;
					end
				end
				S_MOVE: begin
					if (cnt_q != '0) begin
						mv_s1 <= 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						mv_s1 <= 1'b0;
						// wait for the last shifted word to land
						if (!mv_s1) begin
							if (act_q == pal_pkg::ACT_INSERT) begin
								state_q <= S_PUT;
							end else begin
								used_q  <= used_q - 1'b1;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_PUT: begin
					if (status_q == pal_pkg::ST_OK) begin
						used_q <= used_q + 1'b1;
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_idx_q != used_q) begin
						scan_vld_s1 <= 1'b1;
						scan_idx_q  <= scan_idx_q + 1'b1;
					end else begin
						scan_vld_s1 <= 1'b0;
						if (!scan_vld_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			pos_q    <= position;
			val_q    <= value;
			status_q <= plan_status;
			mv_rd_q  <= plan_rd;
			up_q     <= plan_up;
		end
		if (state_q == S_MOVE && cnt_q != '0) begin
			mv_wa_s1 <= up_q ? mv_rd_q - 1'b1 : mv_rd_q + 1'b1;
			mv_rd_q  <= up_q ? mv_rd_q + 1'b1 : mv_rd_q - 1'b1;
		end
		if (state_q == S_SCAN) begin
			scan_ix_s1 <= scan_idx_q[AW-1:0];
		end
	end

	// shifted words go out first; the new word is written after the shift drains
	assign mem_we    = mv_s1 || (state_q == S_PUT);
	assign mem_waddr = mv_s1 ? mv_wa_s1 : pos_q[AW-1:0];
	assign mem_wdata = mv_s1 ? mem_rdata : val_q;
	assign mem_raddr = (state_q == S_SCAN) ? scan_idx_q[AW-1:0] : mv_rd_q;

	pal_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pal_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.vld    (scan_vld_s1),
		.data   (mem_rdata),
		.index  (scan_ix_s1),
		.target (val_q),
		.res    (scan_res)
	);

	assign is_query    = (act_q == pal_pkg::ACT_QUERY);
	assign done        = (state_q == S_DONE);
	assign status      = status_q;
	assign fill        = used_q;
	assign first_index = (is_query && scan_res.present) ?
		{1'b0, scan_res.first} : pal_pkg::NO_INDEX;
	assign present     = is_query && scan_res.present;
	assign match_count = is_query ? scan_res.count : '0;
	assign largest     = scan_res.largest;
	assign smallest    = scan_res.smallest;
	assign empty_res   = (used_q == '0);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CAP) else $error("fill count above capacity");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("result strobe not followed by idle");
	a_put_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> !mv_s1) else $error("new word collides with shift write");
	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (present == (match_count != '0))) else $error("present and count disagree");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == pal_pkg::ST_DROPPED) |-> (fill == CAP))
		else $error("drop reported on a list that is not full");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/positional_array_list_top_tb.sv =====
`timescale 1ns / 1ps
module positional_array_list_top_tb;

	// the one action code that the package leaves unnamed
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [1:0]         action;
		logic [4:0]         position;
		logic signed [31:0] value;
	} pal_request_t;

	typedef struct {
		logic [1:0]         status;
		logic [4:0]         fill;
		logic signed [4:0]  first_index;
		logic               present;
		logic [4:0]         match_count;
		logic signed [31:0] largest;
		logic signed [31:0] smallest;
		logic               empty_res;
	} pal_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         action = pal_pkg::ACT_QUERY;
	logic [4:0]         position = 5'd0;
	logic signed [31:0] value = 32'sd0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [4:0]         fill;
	logic signed [4:0]  first_index;
	logic               present;
	logic [4:0]         match_count;
	logic signed [31:0] largest;
	logic signed [31:0] smallest;
	logic               empty_res;

	positional_array_list_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.fill       (fill),
		.first_index(first_index),
		.present    (present),
		.match_count(match_count),
		.largest    (largest),
		.smallest   (smallest),
		.empty_res  (empty_res)
	);

	always #2 clk = ~clk;

	pal_request_t       pending_requests[$];
	pal_result_t        expected_results[$];
	logic signed [31:0] list_words[pal_pkg::CAPACITY];
	int                 list_fill = 0;
	int                 planned_fill = 0;
	logic signed [31:0] recent_values[$];
	int                 total_requests = 0;
	int                 accepted_count = 0;
	int                 fail_count = 0;
	int                 insert_count = 0;
	int                 delete_count = 0;
	int                 dropped_count = 0;
	int                 rejected_count = 0;
	int                 query_hits = 0;
	int                 peak_fill = 0;
	logic               req_taken = 1'b0;
	int                 burst_left = 0;
	int                 gap_left = 0;
	pal_result_t        list_result;
	pal_request_t       next_req;

	task automatic report_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		$display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
	endtask

	// apply one request to the shadow list and work out what the block must report
	task automatic apply_list_request(input logic [1:0] act, input logic [4:0] pos,
			input logic signed [31:0] val, output pal_result_t res);
		int p;
		int i;
		p = pos;
		res.status = pal_pkg::ST_ERROR;
		res.first_index = pal_pkg::NO_INDEX;
		res.present = 1'b0;
		res.match_count = 5'd0;
		case (act)
			pal_pkg::ACT_INSERT: begin
				if (p <= list_fill && p < pal_pkg::CAPACITY) begin
					if (list_fill < pal_pkg::CAPACITY) begin
						for (i = list_fill; i > p; i--)
							list_words[i] = list_words[i - 1];
						list_fill++;
						res.status = pal_pkg::ST_OK;
					end else begin
						// full: the last entry falls off the end
						for (i = pal_pkg::CAPACITY - 1; i > p; i--)
							list_words[i] = list_words[i - 1];
						res.status = pal_pkg::ST_DROPPED;
					end
					list_words[p] = val;
				end
			end
			pal_pkg::ACT_DELETE: begin
				if (p < list_fill) begin
					for (i = p; i + 1 < list_fill; i++)
						list_words[i] = list_words[i + 1];
					list_fill--;
					res.status = pal_pkg::ST_OK;
				end
			end
			pal_pkg::ACT_QUERY: begin
				res.status = pal_pkg::ST_OK;
				for (i = 0; i < list_fill; i++) begin
					if (list_words[i] == val) begin
						if (!res.present)
							res.first_index = i[4:0];
						res.present = 1'b1;
						res.match_count = res.match_count + 5'd1;
					end
				end
			end
			default: ;
		endcase
		res.fill = list_fill[4:0];
		res.empty_res = (list_fill == 0);
		res.largest = 32'sd0;
		res.smallest = 32'sd0;
		if (list_fill > 0) begin
			res.largest = list_words[0];
			res.smallest = list_words[0];
			for (i = 1; i < list_fill; i++) begin
				if (list_words[i] > res.largest)
					res.largest = list_words[i];
				if (list_words[i] < res.smallest)
					res.smallest = list_words[i];
			end
		end
	endtask

	task automatic check_result(input pal_result_t want);
		if (status !== want.status)
			report_mismatch("status", want.status, status);
		if (fill !== want.fill)
			report_mismatch("fill", want.fill, fill);
		if (first_index !== want.first_index)
			report_mismatch("first_index", want.first_index, first_index);
		if (present !== want.present)
			report_mismatch("present", want.present, present);
		if (match_count !== want.match_count)
			report_mismatch("match_count", want.match_count, match_count);
		if (largest !== want.largest)
			report_mismatch("largest", want.largest, largest);
		if (smallest !== want.smallest)
			report_mismatch("smallest", want.smallest, smallest);
		if (empty_res !== want.empty_res)
			report_mismatch("empty_res", want.empty_res, empty_res);
	endtask

	// track the fill as the stimulus is planned, so positions can aim at valid slots
	task automatic queue_request(input logic [1:0] act, input logic [4:0] pos,
			input logic signed [31:0] val);
		pal_request_t req;
		req.action = act;
		req.position = pos;
		req.value = val;
		pending_requests.push_back(req);
		if (act == pal_pkg::ACT_INSERT && pos <= planned_fill && pos < pal_pkg::CAPACITY) begin
			if (planned_fill < pal_pkg::CAPACITY)
				planned_fill++;
			recent_values.push_back(val);
			if (recent_values.size() > pal_pkg::CAPACITY)
				void'(recent_values.pop_front());
		end else if (act == pal_pkg::ACT_DELETE && pos < planned_fill) begin
			planned_fill--;
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		if (sel == 4)
			return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		if (sel < 7)
			return $signed($urandom_range(0, 8)) - 32'sd4;
		return $signed($urandom);
	endfunction

	// sender: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !req_taken) begin
				// hold the request until it is taken
			end else if (gap_left > 0) begin
				start <= 1'b0;
				action <= 2'($urandom_range(0, 3));
				position <= 5'($urandom_range(0, 31));
				value <= $signed($urandom);
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() > 0) begin
				next_req = pending_requests.pop_front();
				action <= next_req.action;
				position <= next_req.position;
				value <= next_req.value;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// results first, then the request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with no request outstanding", $time);
				end else begin
					check_result(expected_results.pop_front());
				end
			end
			if (start && !busy) begin
				apply_list_request(action, position, value, list_result);
				expected_results.push_back(list_result);
				accepted_count++;
				if (list_result.status == pal_pkg::ST_ERROR)
					rejected_count++;
				else if (action == pal_pkg::ACT_INSERT)
					insert_count++;
				else if (action == pal_pkg::ACT_DELETE)
					delete_count++;
				if (list_result.status == pal_pkg::ST_DROPPED)
					dropped_count++;
				if (list_result.present)
					query_hits++;
				if (list_fill > peak_fill)
					peak_fill = list_fill;
			end
			req_taken <= start && !busy;
		end
	end

	initial begin
		#2_000_000;
		$display("** positional_array_list_top: FAILED **");
		$finish;
	end

	initial begin
		int i;
		int r;
		int pos;
		bit grow;
		logic [1:0] act;

		// directed: empty list, bad positions, extremes, full list
		queue_request(pal_pkg::ACT_QUERY, 5'd0, 32'sd0);
		queue_request(pal_pkg::ACT_DELETE, 5'd0, 32'sd9);
		queue_request(pal_pkg::ACT_INSERT, 5'd1, 32'sd9);
		queue_request(pal_pkg::ACT_INSERT, 5'd0, 32'sh7FFF_FFFF);
		queue_request(pal_pkg::ACT_INSERT, 5'd0, 32'sh8000_0000);
		queue_request(pal_pkg::ACT_INSERT, 5'd2, -32'sd1);
		queue_request(pal_pkg::ACT_INSERT, 5'd1, 32'sd0);
		queue_request(pal_pkg::ACT_INSERT, 5'd31, 32'sd5);
		for (i = 4; i < pal_pkg::CAPACITY; i++)
			queue_request(pal_pkg::ACT_INSERT, (i % 2 == 1) ? i[4:0] : 5'd0, i % 3);
		queue_request(pal_pkg::ACT_INSERT, 5'd16, 32'sd8);
		queue_request(pal_pkg::ACT_INSERT, 5'd5, 32'sd7);
		queue_request(pal_pkg::ACT_INSERT, 5'd15, 32'sd1);
		queue_request(pal_pkg::ACT_QUERY, 5'd31, 32'sd1);
		queue_request(pal_pkg::ACT_QUERY, 5'd0, -32'sd1);
		queue_request(ACT_UNUSED, 5'd31, -32'sd1);
		queue_request(pal_pkg::ACT_DELETE, 5'd16, 32'sd0);
		queue_request(pal_pkg::ACT_DELETE, 5'd15, 32'sd0);
		queue_request(pal_pkg::ACT_DELETE, 5'd0, 32'sd0);

		// random: alternate growing and shrinking so the list crosses empty and full
		grow = 1'b1;
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			if (planned_fill == 0)
				grow = 1'b1;
			else if (planned_fill == pal_pkg::CAPACITY && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if ($urandom_range(0, 19) == 0)
				grow = !grow;
			r = $urandom_range(0, 99);
			if (r < 4)
				act = ACT_UNUSED;
			else if (r < 28)
				act = pal_pkg::ACT_QUERY;
			else if (grow ? (r < 80) : (r < 45))
				act = pal_pkg::ACT_INSERT;
			else
				act = pal_pkg::ACT_DELETE;
			pos = $urandom_range(0, 31);
			if ($urandom_range(0, 99) < 85) begin
				if (act == pal_pkg::ACT_INSERT)
					pos = $urandom_range(0, (planned_fill < pal_pkg::CAPACITY) ?
							planned_fill : pal_pkg::CAPACITY - 1);
				else if (act == pal_pkg::ACT_DELETE && planned_fill > 0)
					pos = $urandom_range(0, planned_fill - 1);
			end
			queue_request(act, pos[4:0], pick_value());
		end
		total_requests = pending_requests.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_requests || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d inserts (%0d dropping the last entry), %0d deletes",
				accepted_count, insert_count, dropped_count, delete_count);
		$display("  %0d queries that found their target, %0d rejected, peak fill %0d",
				query_hits, rejected_count, peak_fill);
		if (fail_count == 0) begin
			$display("** positional_array_list_top: PASSED **");
		end else begin
			$display("** positional_array_list_top: FAILED **");
		end
		$finish;
	end

endmodule
